/* rtl/core/alu16sf_pkg.sv */
package alu16sf_pkg;

  // Opcodes
  localparam logic [4:0] OpZero  = 5'd0;
  localparam logic [4:0] OpPassA = 5'd1;
  localparam logic [4:0] OpNotA  = 5'd2;
  localparam logic [4:0] OpNegA  = 5'd3;
  localparam logic [4:0] OpPassB = 5'd4;
  localparam logic [4:0] OpNotB  = 5'd5;
  localparam logic [4:0] OpNegB  = 5'd6;
  localparam logic [4:0] OpAdd   = 5'd7;
  localparam logic [4:0] OpSubAB = 5'd8;
  localparam logic [4:0] OpSubBA = 5'd9;
  localparam logic [4:0] OpIncA  = 5'd10;
  localparam logic [4:0] OpDecA  = 5'd11;
  localparam logic [4:0] OpIncB  = 5'd12;
  localparam logic [4:0] OpDecB  = 5'd13;
  localparam logic [4:0] OpAnd   = 5'd14;
  localparam logic [4:0] OpNand  = 5'd15;
  localparam logic [4:0] OpOr    = 5'd16;
  localparam logic [4:0] OpNor   = 5'd17;
  localparam logic [4:0] OpXor   = 5'd18;
  localparam logic [4:0] OpShlA  = 5'd19;
  localparam logic [4:0] OpSraA  = 5'd20;
  localparam logic [4:0] OpShlB  = 5'd21;
  localparam logic [4:0] OpSraB  = 5'd22;

  // Stream widths, padded to whole bytes
  localparam int SDataW = 40;
  localparam int MDataW = 24;

  // Request beat, lowest field last
  typedef struct packed {
    logic               clear_flags;
    logic               flags_enable;
    logic signed [15:0] operand_b;
    logic signed [15:0] operand_a;
    logic [4:0]         req_type;
  } req_t;

  // Sticky status flags, zero in the lowest bit
  typedef struct packed {
    logic overflow;
    logic greater;
    logic less;
    logic equal;
    logic negative;
    logic zero;
  } flags_t;

endpackage

/* rtl/core/alu_16bit_sticky_flags.sv */
// 16-bit signed ALU with sticky status flags. Each request beat carries an
// opcode (0..22), two signed operands, a flag-enable bit and a clear bit, and
// produces exactly one result beat holding the wrapped result, the six sticky
// flags as they stand after that beat, and a bad-opcode bit. The flags are
// only ever set by operations; a beat with clear_flags high zeroes them all
// and returns 0. A beat passes through the input register, then the result
// register, and one beat is taken every cycle while the result side drains;
// the sticky flag update is a single OR into the flag register, which sets
// that one-beat-per-cycle figure.
module alu_16bit_sticky_flags
  import alu16sf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // req_type[4:0], operand_a[20:5], operand_b[36:21], flags_enable[37],
  // clear_flags[38], zero pad[39]
  input  logic [SDataW-1:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // result[15:0], zero_out[16], negative_out[17], equal_out[18],
  // less_out[19], greater_out[20], overflow_out[21], bad_opcode[22], pad[23]
  output logic [MDataW-1:0] m_axis_tdata
);

  localparam int ReqW = $bits(req_t);

  // Input register
  logic  in_valid;
  req_t  in_req;

  // Result register
  logic        out_valid;
  logic [15:0] out_result;
  logic        out_bad;
  flags_t      flags;
  flags_t      flags_next;

  logic adv;

  // Stage handshake
  assign adv           = !out_valid || m_axis_tready;
  assign s_axis_tready = !in_valid || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_req <= req_t'(s_axis_tdata[ReqW-1:0]);
    end
  end

  // Datapath
  logic signed [16:0] ax, bx;
  logic signed [16:0] sum_ab, diff_ab, diff_ba, a_inc, a_dec, b_inc, b_dec;
  logic signed [16:0] cmp_diff;
  logic [15:0]        res;
  logic               ovf_hit, cmp_op, bad;

  assign ax      = {in_req.operand_a[15], in_req.operand_a};
  assign bx      = {in_req.operand_b[15], in_req.operand_b};
  assign sum_ab  = ax + bx;
  assign diff_ab = ax - bx;
  assign diff_ba = bx - ax;
  assign a_inc   = ax + 17'sd1;
  assign a_dec   = ax - 17'sd1;
  assign b_inc   = bx + 17'sd1;
  assign b_dec   = bx - 17'sd1;

  always_comb begin
    res      = '0;
    ovf_hit  = 1'b0;
    cmp_op   = 1'b0;
    cmp_diff = diff_ab;
    bad      = 1'b0;
    unique case (in_req.req_type)
      OpZero:  res = '0;
      OpPassA: res = in_req.operand_a;
      OpNotA:  res = ~in_req.operand_a;
      OpNegA:  res = 16'(-ax);
      OpPassB: res = in_req.operand_b;
      OpNotB:  res = ~in_req.operand_b;
      OpNegB:  res = 16'(-bx);
      OpAdd: begin
        res     = sum_ab[15:0];
        ovf_hit = sum_ab[16] ^ sum_ab[15];
      end
      OpSubAB: begin
        res    = diff_ab[15:0];
        cmp_op = 1'b1;
      end
      OpSubBA: begin
        res      = diff_ba[15:0];
        cmp_op   = 1'b1;
        cmp_diff = diff_ba;
      end
      OpIncA: begin
        res     = a_inc[15:0];
        ovf_hit = a_inc[16] ^ a_inc[15];
      end
      OpDecA:  res = a_dec[15:0];
      OpIncB: begin
        res     = b_inc[15:0];
        ovf_hit = b_inc[16] ^ b_inc[15];
      end
      OpDecB:  res = b_dec[15:0];
      OpAnd:   res = in_req.operand_a & in_req.operand_b;
      OpNand:  res = ~(in_req.operand_a & in_req.operand_b);
      OpOr:    res = in_req.operand_a | in_req.operand_b;
      OpNor:   res = ~(in_req.operand_a | in_req.operand_b);
      OpXor:   res = in_req.operand_a ^ in_req.operand_b;
      OpShlA:  res = {in_req.operand_a[14:0], 1'b0};
      OpSraA:  res = {in_req.operand_a[15], in_req.operand_a[15:1]};
      OpShlB:  res = {in_req.operand_b[14:0], 1'b0};
      OpSraB:  res = {in_req.operand_b[15], in_req.operand_b[15:1]};
      default: bad = 1'b1;
    endcase
  end

  // Sticky flag update
  always_comb begin
    flags_next = flags;
    if (in_req.clear_flags) begin
      flags_next = '0;
    end else if (in_req.flags_enable) begin
      flags_next.zero     = flags.zero     | (res == 16'd0);
      flags_next.negative = flags.negative | res[15];
      flags_next.overflow = flags.overflow | ovf_hit;
      flags_next.equal    = flags.equal    | (cmp_op && cmp_diff == 17'sd0);
      flags_next.less     = flags.less     | (cmp_op && cmp_diff[16]);
      flags_next.greater  = flags.greater  |
                            (cmp_op && !cmp_diff[16] && cmp_diff != 17'sd0);
    end
  end

  // Result register and flag state
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      flags     <= '0;
    end else if (adv) begin
      out_valid <= in_valid;
      if (in_valid) begin
        flags <= flags_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      out_result <= in_req.clear_flags ? 16'd0 : res;
      out_bad    <= !in_req.clear_flags && bad;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, out_bad, flags, out_result};

  // A bad opcode always returns zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_bad) |-> (out_result == 16'd0))
    else $error("bad opcode beat with nonzero result");

  // Flags only fall on a clear beat
  assert property (@(posedge clk) disable iff (rst)
    (adv && in_valid && !in_req.clear_flags) |=> ((flags & $past(flags)) == $past(flags)))
    else $error("sticky flag dropped without clear");

  // A clear beat leaves every flag low and no error
  assert property (@(posedge clk) disable iff (rst)
    (adv && in_valid && in_req.clear_flags) |=> (out_valid && flags == '0 && !out_bad))
    else $error("clear beat did not zero the flags");

  // Flags hold while no beat moves into the result register
  assert property (@(posedge clk) disable iff (rst)
    !(adv && in_valid) |=> $stable(flags))
    else $error("flags changed with no beat processed");

endmodule
